>>> rtl/assert_macros.svh
// Assertion macros used by the cache top level.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

>>> rtl/lfu_pkg.sv
// Types, constants and codes shared by the LFU block cache.
// Depends on nothing.
package lfu_pkg;
  localparam int NumEntries = 64;
  localparam int BlockWords = 32;
  localparam int EntW = $clog2(NumEntries);
  localparam int WordW = $clog2(BlockWords);
  localparam int StoreW = EntW + WordW;

  localparam logic [1:0] ReqLookup = 2'd0;
  localparam logic [1:0] ReqInsert = 2'd1;
  localparam logic [1:0] ReqUpdate = 2'd2;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StMiss = 2'd1;
  localparam logic [1:0] StPresent = 2'd2;
  localparam logic [1:0] StDisabled = 2'd3;

  localparam logic CfgEnable = 1'b0;
  localparam logic CfgEntries = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] disk_number;
    logic [7:0] block_number;
    logic [4:0] word_index;
    logic [63:0] data_word;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [63:0] read_word;
    logic [4:0] read_index;
    logic last;
    logic [31:0] hit_count;
    logic [31:0] query_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_SCAN, S_SCANW, S_DECIDE, S_BUMP, S_WRITE, S_RDREQ, S_RDOUT, S_EMIT
  } state_t;

  // Tag entry: valid, key and use count.
  typedef struct packed {
    logic valid;
    logic [3:0] disk;
    logic [7:0] block;
    logic [31:0] uses;
  } tag_t;
endpackage

>>> rtl/lfu_tag_ram.sv
// Tag memory: one entry per cache slot, registered read.
// Depends on lfu_pkg.
module lfu_tag_ram (
  input  logic clk,
  input  logic we,
  input  logic [lfu_pkg::EntW-1:0] waddr,
  input  lfu_pkg::tag_t wdata,
  input  logic [lfu_pkg::EntW-1:0] raddr,
  output lfu_pkg::tag_t rdata
);
  lfu_pkg::tag_t mem [lfu_pkg::NumEntries];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/lfu_data_ram.sv
// Block data memory, one 64-bit word per address, registered read.
// Depends on lfu_pkg.
module lfu_data_ram (
  input  logic clk,
  input  logic we,
  input  logic [lfu_pkg::StoreW-1:0] waddr,
  input  logic [63:0] wdata,
  input  logic [lfu_pkg::StoreW-1:0] raddr,
  output logic [63:0] rdata
);
  logic [63:0] mem [lfu_pkg::NumEntries*lfu_pkg::BlockWords];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/lfu_block_cache_top.sv
// Top level of the LFU block cache: control sequencer, statistics and
// memories. Depends on lfu_pkg, lfu_tag_ram, lfu_data_ram, assert_macros.svh.
//
//  Channel | Signals                         | Direction
//  req     | req_valid, req_stall, req       | in  (req_t)
//  rsp     | rsp_valid, rsp_stall, rsp       | out (rsp_t)
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// While the cache is enabled, a lookup or an index-0 insert/update scans the
// tag memory, one entry a cycle over the entries in use; a lookup hit then
// streams 32 words, each read in RDREQ and RDOUT and offered in EMIT, the next
// only once the last is taken. Later words of an insert/update go straight to
// WRITE and EMIT. Reset sets up a clearing pass over the tag memory, during
// which no item is accepted; enabling the cache runs the same pass. A stalled
// result holds in the output register and the block waits.
`include "assert_macros.svh"
module lfu_block_cache_top (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  lfu_pkg::req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output lfu_pkg::rsp_t rsp,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [6:0] cfg_data
);
  localparam int EW = lfu_pkg::EntW;
  localparam int WW = lfu_pkg::WordW;

  lfu_pkg::state_t state, state_next;
  lfu_pkg::req_t cur;
  logic enabled;
  logic [6:0] entries_in_use;
  logic [31:0] seen, hits;
  logic [EW-1:0] write_slot;
  logic [1:0] write_outcome;
  logic [EW:0] ptr;          // scan/clear pointer, one bit wider to hold the count
  logic [EW:0] scan_n;
  logic found;
  logic [EW-1:0] found_idx;
  logic [31:0] found_uses;
  logic [EW-1:0] victim;
  logic [31:0] victim_uses;
  logic [WW:0] word;

  // Tag and data memory ports.
  logic tag_we;
  logic [EW-1:0] tag_waddr, tag_raddr;
  lfu_pkg::tag_t tag_wdata, tag_rdata;
  logic data_we;
  logic [lfu_pkg::StoreW-1:0] data_waddr, data_raddr;
  logic [63:0] data_rdata;

  lfu_tag_ram u_tag (.clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
                     .raddr(tag_raddr), .rdata(tag_rdata));
  lfu_data_ram u_data (.clk(clk), .we(data_we), .waddr(data_waddr), .wdata(cur.data_word),
                       .raddr(data_raddr), .rdata(data_rdata));

  assign req_stall = (state != lfu_pkg::S_IDLE) || rsp_valid;
  assign cfg_ready = 1'b1;
  wire req_take = req_valid && !req_stall;
  wire rsp_take = rsp_valid && !rsp_stall;
  wire cfg_take = cfg_valid && cfg_ready;
  // Turning the cache on from off starts a clearing pass over the tags.
  wire start_clear = cfg_take && cfg_index == lfu_pkg::CfgEnable && cfg_data[0] && !enabled;

  // Effective scan length, capped at the table size.
  always_comb begin
    if ({1'b0, entries_in_use} > 8'(lfu_pkg::NumEntries)) begin
      scan_n = (EW+1)'(lfu_pkg::NumEntries);
    end else begin
      scan_n = (EW+1)'(entries_in_use);
    end
  end

  wire scan_done = ptr >= scan_n || ptr == (EW+1)'(lfu_pkg::NumEntries);

  wire is_lookup = cur.req_type == lfu_pkg::ReqLookup;
  wire is_insert = cur.req_type == lfu_pkg::ReqInsert;
  wire key_match = tag_rdata.valid && tag_rdata.disk == cur.disk_number &&
                   tag_rdata.block == cur.block_number;

  always_comb begin
    state_next = state;
    tag_we = 1'b0;
    tag_waddr = write_slot;
    tag_wdata = '0;
    tag_raddr = ptr[EW-1:0];
    data_we = 1'b0;
    data_waddr = {write_slot, cur.word_index[WW-1:0]};
    data_raddr = {found_idx, word[WW-1:0]};
    case (state)
      lfu_pkg::S_IDLE: begin
        if (req_take) begin
          if (req.req_type == lfu_pkg::ReqLookup) begin
            state_next = enabled ? lfu_pkg::S_SCAN : lfu_pkg::S_EMIT;
          end else if (req.req_type == lfu_pkg::ReqInsert ||
                       req.req_type == lfu_pkg::ReqUpdate) begin
            state_next = (req.word_index == '0 && enabled) ? lfu_pkg::S_SCAN
                                                          : lfu_pkg::S_WRITE;
          end
        end
      end
      lfu_pkg::S_CLEAR: begin
        tag_we = 1'b1;
        tag_waddr = ptr[EW-1:0];
        if (ptr == (EW+1)'(lfu_pkg::NumEntries - 1)) begin
          state_next = lfu_pkg::S_IDLE;
        end
      end
      lfu_pkg::S_SCAN: begin
        state_next = lfu_pkg::S_SCANW;
      end
      lfu_pkg::S_SCANW: begin
        // tag_rdata holds entry ptr-1.
        if (scan_done) begin
          state_next = lfu_pkg::S_DECIDE;
        end
      end
      lfu_pkg::S_DECIDE: begin
        if (is_lookup) begin
          state_next = found ? lfu_pkg::S_BUMP : lfu_pkg::S_EMIT;
        end else begin
          state_next = lfu_pkg::S_BUMP;
        end
      end
      lfu_pkg::S_BUMP: begin
        if (is_lookup) begin
          tag_we = 1'b1;
          tag_waddr = found_idx;
          tag_wdata = '{valid: 1'b1, disk: cur.disk_number, block: cur.block_number,
                        uses: (found_uses == '1) ? found_uses : found_uses + 32'd1};
          state_next = lfu_pkg::S_RDREQ;
        end else begin
          if (write_outcome == lfu_pkg::StOk) begin
            tag_we = 1'b1;
            tag_wdata = '{valid: 1'b1, disk: cur.disk_number, block: cur.block_number,
                          uses: 32'd1};
          end
          state_next = lfu_pkg::S_WRITE;
        end
      end
      lfu_pkg::S_WRITE: begin
        data_we = (write_outcome == lfu_pkg::StOk);
        state_next = lfu_pkg::S_EMIT;
      end
      lfu_pkg::S_RDREQ: begin
        state_next = lfu_pkg::S_RDOUT;
      end
      lfu_pkg::S_RDOUT: begin
        state_next = lfu_pkg::S_EMIT;
      end
      lfu_pkg::S_EMIT: begin
        if (rsp_take) begin
          if (is_lookup && found && enabled &&
              word != (WW+1)'(lfu_pkg::BlockWords)) begin
            state_next = lfu_pkg::S_RDREQ;
          end else begin
            state_next = lfu_pkg::S_IDLE;
          end
        end
      end
      default: state_next = lfu_pkg::S_IDLE;
    endcase
    if (start_clear) begin
      state_next = lfu_pkg::S_CLEAR;
    end
  end

  // The pointer walks the tags during a clearing pass and during a scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (start_clear || (state == lfu_pkg::S_IDLE && req_take)) begin
      ptr <= '0;
    end else if (state == lfu_pkg::S_CLEAR || state == lfu_pkg::S_SCAN ||
                 (state == lfu_pkg::S_SCANW && !scan_done)) begin
      ptr <= ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfu_pkg::S_CLEAR;
      enabled <= 1'b0;
      entries_in_use <= 7'd64;
      seen <= '0;
      hits <= '0;
      write_slot <= '0;
      write_outcome <= lfu_pkg::StOk;
      rsp_valid <= 1'b0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_take) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_take) begin
        if (cfg_index == lfu_pkg::CfgEnable) begin
          enabled <= cfg_data[0];
        end else begin
          entries_in_use <= cfg_data;
        end
      end
      case (state)
        lfu_pkg::S_IDLE: begin
          if (req_take) begin
            cur <= req;
            found <= 1'b0;
            victim <= '0;
            victim_uses <= '1;
            word <= '0;
            if (req.req_type == lfu_pkg::ReqLookup && seen != '1) begin
              seen <= seen + 32'd1;
            end
          end
        end
        lfu_pkg::S_SCANW: begin
          // Entry ptr-1 is on the read port; entry 0 always counts for the victim.
          if (key_match && !found && (ptr - 1'b1) < scan_n) begin
            found <= 1'b1;
            found_idx <= EW'(ptr - 1'b1);
            found_uses <= tag_rdata.uses;
          end
          if (ptr == (EW+1)'(1) || ((ptr - 1'b1) < scan_n && tag_rdata.uses < victim_uses)) begin
            victim <= EW'(ptr - 1'b1);
            victim_uses <= tag_rdata.uses;
          end
        end
        lfu_pkg::S_DECIDE: begin
          if (is_lookup) begin
            if (found && hits != '1) begin
              hits <= hits + 32'd1;
            end
          end else if (is_insert) begin
            if (found) begin
              write_outcome <= lfu_pkg::StPresent;
            end else begin
              write_outcome <= lfu_pkg::StOk;
              write_slot <= victim;
            end
          end else begin
            if (found) begin
              write_outcome <= lfu_pkg::StOk;
              write_slot <= found_idx;
            end else begin
              write_outcome <= lfu_pkg::StMiss;
            end
          end
        end
        lfu_pkg::S_WRITE: begin
          rsp_valid <= 1'b1;
          rsp.status <= write_outcome;
          rsp.read_word <= '0;
          rsp.read_index <= cur.word_index;
          rsp.last <= cur.word_index == 5'(lfu_pkg::BlockWords - 1);
          rsp.hit_count <= hits;
          rsp.query_count <= seen;
        end
        lfu_pkg::S_RDOUT: begin
          rsp_valid <= 1'b1;
          rsp.status <= lfu_pkg::StOk;
          rsp.read_word <= data_rdata;
          rsp.read_index <= 5'(word);
          rsp.last <= word == (WW+1)'(lfu_pkg::BlockWords - 1);
          rsp.hit_count <= hits;
          rsp.query_count <= seen;
          word <= word + 1'b1;
        end
        lfu_pkg::S_EMIT: begin
          if (!rsp_valid && !rsp_take && is_lookup && !(found && enabled)) begin
            rsp_valid <= 1'b1;
            rsp.status <= enabled ? lfu_pkg::StMiss : lfu_pkg::StDisabled;
            rsp.read_word <= '0;
            rsp.read_index <= '0;
            rsp.last <= 1'b1;
            rsp.hit_count <= hits;
            rsp.query_count <= seen;
          end
        end
        default: ;
      endcase
      // Index-0 insert/update while disabled takes the disabled outcome.
      if (state == lfu_pkg::S_IDLE && req_take && !enabled && req.word_index == '0 &&
          (req.req_type == lfu_pkg::ReqInsert || req.req_type == lfu_pkg::ReqUpdate)) begin
        write_outcome <= lfu_pkg::StDisabled;
      end
    end
  end

  `ASSERT_IMPLIES(a_no_take_busy, clk, rst, state != lfu_pkg::S_IDLE, !req_take)
  `ASSERT_NEXT(a_hit_counts, clk, rst, state == lfu_pkg::S_DECIDE && is_lookup && found &&
    hits != '1, hits == $past(hits) + 32'd1)
  `ASSERT_IMPLIES(a_write_ok, clk, rst, data_we, write_outcome == lfu_pkg::StOk)
  `ASSERT_IMPLIES(a_hits_le_seen, clk, rst, 1'b1, hits <= seen)
endmodule

>>> sim/tb.sv
// Self-checking testbench for the LFU block cache top level.
// Depends on lfu_pkg and lfu_block_cache_top; it predicts each response in-line.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumEntries = lfu_pkg::NumEntries;
  localparam int BlockWords = lfu_pkg::BlockWords;
  localparam int NumPhases = 8;
  localparam int PhaseItems = 50;
  localparam int IdleWait = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  lfu_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  lfu_pkg::rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [6:0] cfg_data = '0;

  lfu_block_cache_top DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // The clock runs at 100 MHz.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Requests waiting for the driver, and responses the cache should return,
  // oldest first.
  lfu_pkg::req_t pending_reqs[$];
  lfu_pkg::rsp_t expected_rsps[$];

  int mismatches = 0;
  int unexpected = 0;
  int rsps_checked = 0;
  int reqs_sent = 0;
  int hits_predicted = 0;

  // Shadow copy of the cache state, kept in step with the requests as they
  // are queued. The queue order is the order the cache sees them in.
  logic        sh_enabled;
  logic [6:0]  sh_entries;
  logic        sh_valid[NumEntries];
  logic [3:0]  sh_disk[NumEntries];
  logic [7:0]  sh_block[NumEntries];
  logic [31:0] sh_uses[NumEntries];
  logic [63:0] sh_store[NumEntries*BlockWords];
  logic [31:0] sh_written[NumEntries];
  logic [31:0] sh_queries;
  logic [31:0] sh_hits;
  logic [5:0]  sh_wslot;
  logic [1:0]  sh_woutcome;

  // Small key pool so that lookups, duplicate inserts and updates hit often.
  logic [3:0] pool_disk[8];
  logic [7:0] pool_block[8];

  function automatic int scan_len();
    return (sh_entries > NumEntries) ? NumEntries : int'(sh_entries);
  endfunction

  function automatic int find_entry(logic [3:0] d, logic [7:0] b);
    int n;
    n = scan_len();
    for (int i = 0; i < n; i++)
      if (sh_valid[i] && sh_disk[i] == d && sh_block[i] == b) return i;
    return -1;
  endfunction

  function automatic int least_used();
    int n;
    int v;
    n = scan_len();
    v = 0;
    for (int i = 1; i < n; i++)
      if (sh_uses[v] > sh_uses[i]) v = i;
    return v;
  endfunction

  function automatic void clear_tags();
    for (int i = 0; i < NumEntries; i++) begin
      sh_valid[i] = 1'b0;
      sh_disk[i] = '0;
      sh_block[i] = '0;
      sh_uses[i] = '0;
    end
  endfunction

  function automatic lfu_pkg::rsp_t make_rsp(logic [1:0] st, logic [63:0] w, logic [4:0] idx,
                                             logic lst);
    lfu_pkg::rsp_t r;
    r.status = st;
    r.read_word = w;
    r.read_index = idx;
    r.last = lst;
    r.hit_count = sh_hits;
    r.query_count = sh_queries;
    return r;
  endfunction

  // Advances the shadow state by one request and queues its responses.
  function automatic void predict_cache(lfu_pkg::req_t r);
    int h;
    if (r.req_type == lfu_pkg::ReqLookup) begin
      if (sh_queries != 32'hFFFF_FFFF) sh_queries++;
      if (!sh_enabled) begin
        expected_rsps.push_back(make_rsp(lfu_pkg::StDisabled, '0, '0, 1'b1));
        return;
      end
      h = find_entry(r.disk_number, r.block_number);
      if (h < 0) begin
        expected_rsps.push_back(make_rsp(lfu_pkg::StMiss, '0, '0, 1'b1));
        return;
      end
      if (sh_hits != 32'hFFFF_FFFF) sh_hits++;
      if (sh_uses[h] != 32'hFFFF_FFFF) sh_uses[h]++;
      hits_predicted++;
      for (int w = 0; w < BlockWords; w++)
        expected_rsps.push_back(make_rsp(lfu_pkg::StOk, sh_store[h*BlockWords+w], 5'(w),
                                         w == BlockWords - 1));
    end else if (r.req_type == lfu_pkg::ReqInsert || r.req_type == lfu_pkg::ReqUpdate) begin
      if (r.word_index == 0) begin
        if (!sh_enabled) sh_woutcome = lfu_pkg::StDisabled;
        else if (r.req_type == lfu_pkg::ReqInsert) begin
          if (find_entry(r.disk_number, r.block_number) >= 0)
            sh_woutcome = lfu_pkg::StPresent;
          else begin
            sh_wslot = 6'(least_used());
            sh_valid[sh_wslot] = 1'b1;
            sh_disk[sh_wslot] = r.disk_number;
            sh_block[sh_wslot] = r.block_number;
            sh_uses[sh_wslot] = 32'd1;
            sh_woutcome = lfu_pkg::StOk;
          end
        end else begin
          h = find_entry(r.disk_number, r.block_number);
          if (h < 0) sh_woutcome = lfu_pkg::StMiss;
          else begin
            sh_wslot = 6'(h);
            sh_uses[h] = 32'd1;
            sh_woutcome = lfu_pkg::StOk;
          end
        end
      end
      if (sh_woutcome == lfu_pkg::StOk) begin
        sh_store[sh_wslot*BlockWords+r.word_index] = r.data_word;
        sh_written[sh_wslot][r.word_index] = 1'b1;
      end
      expected_rsps.push_back(make_rsp(sh_woutcome, '0, r.word_index,
                                       r.word_index == BlockWords - 1));
    end
  endfunction

  task automatic queue_req(logic [1:0] t, logic [3:0] d, logic [7:0] b, logic [4:0] w,
                           logic [63:0] data);
    lfu_pkg::req_t r;
    r.req_type = t;
    r.disk_number = d;
    r.block_number = b;
    r.word_index = w;
    r.data_word = data;
    pending_reqs.push_back(r);
    predict_cache(r);
    reqs_sent++;
  endtask

  // A lookup must never land on an entry whose block was only partly written.
  function automatic bit lookup_is_safe(logic [3:0] d, logic [7:0] b);
    int h;
    if (!sh_enabled) return 1'b1;
    h = find_entry(d, b);
    return (h < 0) || (sh_written[h] == 32'hFFFF_FFFF);
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_valid)
      @(posedge clk);
    // A request type with no response may still be in flight.
    repeat (IdleWait) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == lfu_pkg::CfgEnable) begin
      if (val[0] && !sh_enabled) clear_tags();
      sh_enabled = val[0];
    end else sh_entries = val;
  endtask

  task automatic queue_run(logic [1:0] t, logic [3:0] d, logic [7:0] b, int first, int len);
    for (int w = first; w < first + len && w < BlockWords; w++)
      queue_req(t, d, b, 5'(w), {$urandom, $urandom});
  endtask

  // Driver: bursts of back-to-back transfers separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!req_valid || !req_stall) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        req <= pending_reqs.pop_front();
        req_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks every response transfer against the oldest prediction and
  // drives the response stall from a pattern that changes mode now and then.
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    lfu_pkg::rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          unexpected++;
          if (mismatches + unexpected <= 10)
            $display("%0t: response with nothing expected: %p", $realtime, rsp);
        end else begin
          want = expected_rsps.pop_front();
          rsps_checked++;
          if (rsp.status !== want.status || rsp.read_word !== want.read_word ||
              rsp.read_index !== want.read_index || rsp.last !== want.last ||
              rsp.hit_count !== want.hit_count || rsp.query_count !== want.query_count) begin
            mismatches++;
            if (mismatches + unexpected <= 10)
              $display("%0t: mismatch\n  expected %p\n  actual   %p", $realtime, want, rsp);
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(16, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 9) < 3);
        default: rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Stimulus: reset, a short directed part, then phases of random traffic, each
  // under its own register settings.
  initial begin
    int target;
    int pick;
    int en_set[NumPhases];
    int n_set[NumPhases];
    logic [3:0] d;
    logic [7:0] b;

    sh_enabled = 1'b0;
    sh_entries = 7'd64;
    clear_tags();
    for (int i = 0; i < NumEntries*BlockWords; i++) sh_store[i] = '0;
    for (int i = 0; i < NumEntries; i++) sh_written[i] = '0;
    sh_queries = '0;
    sh_hits = '0;
    sh_wslot = '0;
    sh_woutcome = lfu_pkg::StOk;
    pool_disk[0] = 4'd0;
    pool_block[0] = 8'd0;
    pool_disk[1] = 4'd15;
    pool_block[1] = 8'd255;
    for (int i = 2; i < 8; i++) begin
      pool_disk[i] = 4'($urandom);
      pool_block[i] = 8'($urandom);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: the cache starts disabled. A stray word before any run start
    // follows the reset decision, success into entry zero.
    queue_req(lfu_pkg::ReqInsert, 4'd3, 8'd9, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_req(lfu_pkg::ReqLookup, 4'd15, 8'd255, 5'd0, '0);
    queue_req(lfu_pkg::ReqLookup, 4'd0, 8'd0, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_req(lfu_pkg::ReqInsert, 4'd1, 8'd1, 5'd0, 64'h0123_4567_89AB_CDEF);
    queue_req(lfu_pkg::ReqInsert, 4'd1, 8'd1, 5'd1, 64'd0);
    queue_req(lfu_pkg::ReqUpdate, 4'd2, 8'd2, 5'd0, 64'hDEAD_BEEF_0000_0001);
    queue_req(lfu_pkg::ReqUpdate, 4'd2, 8'd2, 5'd31, 64'hDEAD_BEEF_0000_0002);
    queue_req(2'd3, 4'd15, 8'd255, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_req(lfu_pkg::ReqLookup, 4'd1, 8'd1, 5'd0, '0);

    // Register settings per phase, the extremes among them. Disabling and
    // enabling again clears the tags.
    en_set = '{1, 1, 0, 1, 1, 1, 1, 1};
    n_set = '{64, 2, 64, 0, 127, 1, 3 + $urandom_range(0, 60), 64};

    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      write_reg(lfu_pkg::CfgEnable, 7'(en_set[p]));
      write_reg(lfu_pkg::CfgEntries, 7'(n_set[p]));
      target = reqs_sent + PhaseItems;
      while (reqs_sent < target) begin
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) begin
          d = 4'($urandom);
          b = 8'($urandom);
        end else begin
          d = pool_disk[$urandom_range(0, 7)];
          b = pool_block[$urandom_range(0, 7)];
        end
        if (pick < 45) begin
          if (lookup_is_safe(d, b))
            queue_req(lfu_pkg::ReqLookup, d, b, 5'($urandom), {$urandom, $urandom});
        end else if (pick < 65) begin
          queue_run(lfu_pkg::ReqInsert, d, b, 0, BlockWords);
        end else if (pick < 77) begin
          queue_run(lfu_pkg::ReqUpdate, d, b, 0, BlockWords);
        end else if (pick < 88) begin
          // Broken run: short, and not always started at word zero.
          queue_run(($urandom_range(0, 1) == 0) ? lfu_pkg::ReqInsert : lfu_pkg::ReqUpdate,
                    d, b, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 31),
                    $urandom_range(1, 5));
        end else begin
          pick = $urandom_range(0, 3);
          if (pick != lfu_pkg::ReqLookup || lookup_is_safe(d, b))
            queue_req(2'(pick), d, b, 5'($urandom), {$urandom, $urandom});
        end
      end
    end

    wait_idle();
    $display("Ran %0d requests over %0d register settings; checked %0d responses, %0d lookup hits.",
             reqs_sent, NumPhases, rsps_checked, hits_predicted);
    $display("Mismatches: %0d, unexpected responses: %0d, missing: %0d.",
             mismatches, unexpected, expected_rsps.size());
    if (mismatches == 0 && unexpected == 0 && expected_rsps.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10ms;
    $display("Timeout with %0d responses outstanding.", expected_rsps.size());
    $display("*** FAILED ***");
    $finish;
  end
endmodule
